FILE: hw/rtl/pgr_pkg.sv
package pgr_pkg;

  localparam int unsigned FrameSlotsDefault = 32;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgPolicyMode  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgFramesInUse = 8'd1;

  localparam logic [5:0] FramesReset = 6'd31;

  typedef enum logic {
    PolicyFifo = 1'b0,
    PolicyLru  = 1'b1
  } policy_e;

  typedef struct packed {
    logic [7:0] page_number;
    logic       clear_count;
  } pgr_in_t;

  typedef struct packed {
    logic        hit;
    logic        evicted_valid;
    logic [7:0]  evicted_page;
    logic [15:0] miss_total;
  } pgr_out_t;

  // Controls broadcast from the top level to every cell.
  typedef struct packed {
    logic       lru_shift;
    logic       evict_shift;
    logic [7:0] ref_page;
  } pgr_ctrl_t;

endpackage

FILE: hw/rtl/pgr_cell.sv
module pgr_cell import pgr_pkg::*; (
  input  logic       clk_i,
  input  pgr_ctrl_t  ctrl_i,
  input  logic       valid_i,
  input  logic       write_i,
  input  logic       prefix_i,
  input  logic [7:0] nb_page_i,
  output logic       match_o,
  output logic       prefix_o,
  output logic [7:0] page_o
);

  logic [7:0] page_q, page_d;
  logic       shift;

  assign match_o  = valid_i && (page_q == ctrl_i.ref_page);
  assign prefix_o = prefix_i || match_o;

  // A removal at or before this slot pulls the entry from the right neighbor.
  assign shift = (ctrl_i.lru_shift && prefix_o) || ctrl_i.evict_shift;

  always_comb begin
    page_d = page_q;
    if (write_i) begin
      page_d = ctrl_i.ref_page;
    end else if (shift) begin
      page_d = nb_page_i;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign page_o = page_q;

endmodule

FILE: hw/rtl/page_replacement_fifo_lru.sv
// An accepted reference has its result in the output register in the next cycle.
// Throughput: one reference per cycle; every frame cell compares and shifts in the
// same cycle. The input stalls only while a finished result sits in a stalled output.
// Reset: asynchronous, active low; clears occupancy, miss counter and output valid,
// and sets LRU policy with 31 frames. Frame contents are not cleared.
module page_replacement_fifo_lru import pgr_pkg::*; #(
  parameter int unsigned FrameSlots = FrameSlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pgr_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pgr_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(FrameSlots + 1);
  localparam int unsigned LimW = (CntW > 6) ? CntW : 6;

  logic [CntW-1:0] count_q, count_d;
  logic [15:0]     miss_q, miss_d;
  policy_e         policy_q;
  logic [5:0]      frames_q;
  logic            out_valid_q, out_valid_d;
  pgr_out_t        out_data_q, out_data_d;

  logic            accept;
  logic            hit, miss, evict, remove;
  logic [LimW-1:0] lim_ext, cnt_ext;
  logic [CntW-1:0] wp;
  logic [15:0]     miss_base;
  pgr_ctrl_t       ctrl;

  logic [FrameSlots-1:0] match, valid, write;
  logic [FrameSlots:0]   prefix;
  logic [7:0]            page [FrameSlots];
  logic [7:0]            nb_page [FrameSlots];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= PolicyLru;
      frames_q <= FramesReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPolicyMode:  policy_q <= policy_e'(cfg_data_i[0]);
        CfgFramesInUse: frames_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Effective frame limit clamped to one through FrameSlots.
  always_comb begin
    lim_ext = (frames_q == 6'd0) ? LimW'(1) : LimW'(frames_q);
    if (lim_ext > LimW'(FrameSlots)) begin
      lim_ext = LimW'(FrameSlots);
    end
  end

  assign cnt_ext = LimW'(count_q);
  assign hit     = |match;
  assign miss    = !hit;
  assign evict   = miss && (cnt_ext >= lim_ext) && (count_q != '0);
  assign remove  = (hit && (policy_q == PolicyLru)) || evict;
  assign wp      = remove ? (count_q - CntW'(1)) : count_q;

  assign ctrl.lru_shift   = accept && hit && (policy_q == PolicyLru);
  assign ctrl.evict_shift = accept && evict;
  assign ctrl.ref_page    = in_data_i.page_number;

  assign prefix[0] = 1'b0;

  for (genvar i = 0; i < FrameSlots; i++) begin : g_cell
    assign valid[i]   = CntW'(i) < count_q;
    assign write[i]   = accept && (remove || miss) && (wp == CntW'(i));
    assign nb_page[i] = (i == FrameSlots - 1) ? in_data_i.page_number
                                              : page[(i + 1) % FrameSlots];
    pgr_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .valid_i   (valid[i]),
      .write_i   (write[i]),
      .prefix_i  (prefix[i]),
      .nb_page_i (nb_page[i]),
      .match_o   (match[i]),
      .prefix_o  (prefix[i+1]),
      .page_o    (page[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    miss_d      = miss_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    miss_base   = in_data_i.clear_count ? 16'd0 : miss_q;
    if (accept) begin
      out_valid_d = 1'b1;
      miss_d      = miss_base;
      if (miss) begin
        if (miss_base != 16'hFFFF) begin
          miss_d = miss_base + 16'd1;
        end
        if (!evict) begin
          count_d = count_q + CntW'(1);
        end
      end
      out_data_d.hit           = hit;
      out_data_d.evicted_valid = evict;
      out_data_d.evicted_page  = evict ? page[0] : 8'd0;
      out_data_d.miss_total    = miss_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      miss_q      <= miss_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
